[sv/proxy_v2_header_parser_top_defines.svh]
// Assertion macros shared by the checker of the PROXY v2 header parser.
// Depends on nothing; included by the checker file only.
`ifndef PROXY_V2_HEADER_PARSER_TOP_DEFINES_SVH
`define PROXY_V2_HEADER_PARSER_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define PVH_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define PVH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/pvh_pkg.sv]
// Package of the PROXY v2 header parser: constants, codes and shared types.
// Depends on nothing; used by every module of the block but pvh_ram.
package pvh_pkg;

  localparam int ID_STORE_BYTES = 32;
  localparam int ID_AW = (ID_STORE_BYTES > 1) ? $clog2(ID_STORE_BYTES) : 1;
  localparam int ID_CW = $clog2(ID_STORE_BYTES + 1);

  localparam logic [7:0] CMD_LOCAL = 8'h20;
  localparam logic [7:0] FAM_IPV4 = 8'h11;
  localparam logic [7:0] FAM_IPV6 = 8'h21;
  localparam logic [7:0] TLV_EPID = 8'hea;
  localparam logic [7:0] TLV_ID8 = 8'he0;
  localparam logic [7:0] TLV_ID5 = 8'hee;
  localparam logic [7:0] ID5_VERSION = 8'h01;
  localparam logic [16:0] IPV4_END = 17'd27;
  localparam logic [16:0] IPV6_END = 17'd51;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_FAMILY = 3'd1;
  localparam logic [2:0] ST_BAD_ID8_LEN = 3'd2;
  localparam logic [2:0] ST_BAD_ID5_LEN = 3'd3;
  localparam logic [2:0] ST_BAD_ID5_VER = 3'd4;
  localparam logic [2:0] ST_EMPTY_EPID = 3'd5;

  localparam logic [1:0] KIND_LOCAL = 2'd0;
  localparam logic [1:0] KIND_IPV4 = 2'd1;
  localparam logic [1:0] KIND_IPV6 = 2'd2;
  localparam logic [1:0] KIND_IDBYTE = 2'd3;

  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_EPID = 2'd1;
  localparam logic [1:0] SRC_ID8 = 2'd2;
  localparam logic [1:0] SRC_ID5 = 2'd3;

  typedef enum logic [2:0] {
    PH_TYPE, PH_LEN_HI, PH_LEN_LO, PH_VALUE, PH_SKIP, PH_STOP
  } tlv_phase_t;

  typedef enum logic [1:0] {
    S_PARSE, S_SUMMARY, S_IDREAD, S_IDOUT
  } ctl_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic clear;       // restart the parse on frame start
    logic take_byte;   // absorb the accepted byte
    logic rd_start;    // begin reading the id store from entry zero
    logic rd_next;     // advance the id store read pointer
  } pvh_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic              hdr_end;   // this byte finishes the header
    logic [ID_CW-1:0]  id_count;
    logic              rd_last;   // read pointer is at the last stored byte
  } pvh_stat_t;

endpackage

[sv/pvh_ram.sv]
// Generic single-port-write, registered-read RAM.
// Depends on nothing.
module pvh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]               wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/pvh_ctrl.sv]
// Controller of the PROXY v2 header parser: handshakes and record sequencing.
// Depends on pvh_pkg.
module pvh_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                frame_start,
  output logic                in_ready,
  output logic                out_load_sum,
  output logic                out_load_id,
  input  logic                out_free,
  output pvh_pkg::pvh_cmd_t   cmd,
  input  pvh_pkg::pvh_stat_t  stat
);

  pvh_pkg::ctl_state_t state, state_next;
  logic acc;

  assign acc = in_valid && in_ready;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pvh_pkg::S_PARSE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      pvh_pkg::S_PARSE: begin
        if (acc && stat.hdr_end) state_next = pvh_pkg::S_SUMMARY;
      end
      pvh_pkg::S_SUMMARY: begin
        if (out_free) begin
          state_next = (stat.id_count == '0) ? pvh_pkg::S_PARSE : pvh_pkg::S_IDREAD;
        end
      end
      pvh_pkg::S_IDREAD: state_next = pvh_pkg::S_IDOUT;
      pvh_pkg::S_IDOUT: begin
        if (out_free) begin
          state_next = stat.rd_last ? pvh_pkg::S_PARSE : pvh_pkg::S_IDREAD;
        end
      end
      default: state_next = pvh_pkg::S_PARSE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready = 1'b0;
    out_load_sum = 1'b0;
    out_load_id = 1'b0;
    cmd = '0;
    unique case (state)
      pvh_pkg::S_PARSE: begin
        in_ready = 1'b1;
        cmd.clear = acc && frame_start;
        cmd.take_byte = acc;
      end
      pvh_pkg::S_SUMMARY: begin
        out_load_sum = out_free;
        cmd.rd_start = 1'b1;
      end
      pvh_pkg::S_IDREAD: ;
      pvh_pkg::S_IDOUT: begin
        out_load_id = out_free;
        cmd.rd_next = out_free;
      end
      default: ;
    endcase
  end

endmodule

[sv/pvh_dp.sv]
// Datapath of the PROXY v2 header parser: header fields, TLV walk, id store.
// Depends on pvh_pkg and pvh_ram.
module pvh_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         data_byte,
  input  pvh_pkg::pvh_cmd_t  cmd,
  output pvh_pkg::pvh_stat_t stat,
  output logic [2:0]         sum_status,
  output logic [1:0]         sum_kind,
  output logic [63:0]        addr0,
  output logic [63:0]        addr1,
  output logic [63:0]        addr2,
  output logic [63:0]        addr3,
  output logic [15:0]        port0,
  output logic [15:0]        port1,
  output logic [1:0]         sum_src,
  output logic [63:0]        sum_vpc_id,
  output logic [7:0]         rd_byte
);

  localparam int AW = pvh_pkg::ID_AW;
  localparam int CW = pvh_pkg::ID_CW;

  logic [16:0] byte_position;
  logic [7:0]  ver_cmd_byte;
  logic [7:0]  family_byte;
  logic [16:0] total_length;
  logic [63:0] aw [4];
  logic [15:0] pw [2];
  pvh_pkg::tlv_phase_t tlv_phase;
  logic [7:0]  tlv_type;
  logic [15:0] tlv_length;
  logic [15:0] tlv_offset;
  logic [63:0] id_accumulator;
  logic [CW-1:0] id_count;
  logic [2:0]  status_reg;
  logic        done_flag;
  logic [AW-1:0] rd_ptr;

  // Per-byte decode of the current frame (after an optional restart).
  logic [16:0] pos;
  logic [7:0]  vc, fam;
  logic [16:0] tlen;
  logic        done_eff;
  logic        is_local, is_v4, is_v6;
  logic        in_tlv;
  logic [15:0] len_full;
  logic [15:0] off_inc;
  logic        store_we;

  assign pos = cmd.clear ? 17'd0 : byte_position;
  assign vc = cmd.clear ? 8'd0 : ver_cmd_byte;
  assign fam = cmd.clear ? 8'd0 : family_byte;
  assign tlen = cmd.clear ? 17'd0 : total_length;
  assign done_eff = cmd.clear ? 1'b0 : done_flag;
  assign is_local = (vc == pvh_pkg::CMD_LOCAL);
  assign is_v4 = !is_local && fam == pvh_pkg::FAM_IPV4;
  assign is_v6 = !is_local && fam == pvh_pkg::FAM_IPV6;
  assign in_tlv = (is_v4 && pos > pvh_pkg::IPV4_END) || (is_v6 && pos > pvh_pkg::IPV6_END);
  assign len_full = {tlv_length[15:8], data_byte};
  assign off_inc = tlv_offset + 16'd1;

  // The header ends on the byte whose successor position reaches the length.
  logic [16:0] tlen_now;
  logic [17:0] pos_inc;
  assign tlen_now = (pos == 17'd15) ? ({tlen[16:8], data_byte} + 17'd16) : tlen;
  assign pos_inc = {1'b0, pos} + 18'd1;
  assign stat.hdr_end = !done_eff && pos >= 17'd15 && pos_inc >= {1'b0, tlen_now};
  assign stat.id_count = id_count;
  assign stat.rd_last = ({{(CW-AW){1'b0}}, rd_ptr} + CW'(1)) >= id_count;

  assign store_we = cmd.take_byte && !done_eff && in_tlv && tlv_phase == pvh_pkg::PH_VALUE
                    && tlv_type == pvh_pkg::TLV_EPID && tlv_offset != 16'd0
                    && id_count < CW'(pvh_pkg::ID_STORE_BYTES);

  // Header field, address and TLV registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      ver_cmd_byte <= '0;
      family_byte <= '0;
      total_length <= '0;
      aw <= '{default: '0};
      pw <= '{default: '0};
      tlv_phase <= pvh_pkg::PH_TYPE;
      tlv_type <= '0;
      tlv_length <= '0;
      tlv_offset <= '0;
      id_accumulator <= '0;
      id_count <= '0;
      status_reg <= pvh_pkg::ST_OK;
      done_flag <= 1'b0;
    end else if (cmd.take_byte) begin
      // The position restarts through pos below.
      if (cmd.clear) begin
        ver_cmd_byte <= '0;
        family_byte <= '0;
        total_length <= '0;
        aw <= '{default: '0};
        pw <= '{default: '0};
        tlv_phase <= pvh_pkg::PH_TYPE;
        tlv_type <= '0;
        tlv_length <= '0;
        tlv_offset <= '0;
        id_accumulator <= '0;
        id_count <= '0;
        status_reg <= pvh_pkg::ST_OK;
        done_flag <= 1'b0;
      end
      if (!done_eff) begin
        byte_position <= pos_inc[16:0];
        if (stat.hdr_end) begin
          done_flag <= 1'b1;
          if (!is_local && !is_v4 && !is_v6) status_reg <= pvh_pkg::ST_BAD_FAMILY;
        end
        if (pos == 17'd12) ver_cmd_byte <= data_byte;
        if (pos == 17'd13) family_byte <= data_byte;
        if (pos == 17'd14) total_length <= {1'b0, data_byte, 8'd0};
        if (pos == 17'd15) total_length <= tlen_now;
        // Address and port capture, big-endian.
        if (pos >= 17'd16 && is_v4 && pos <= pvh_pkg::IPV4_END) begin
          if (pos < 17'd20) aw[1] <= {32'd0, aw[1][23:0], data_byte};
          else if (pos < 17'd24) aw[3] <= {32'd0, aw[3][23:0], data_byte};
          else if (pos < 17'd26) pw[0] <= {pw[0][7:0], data_byte};
          else pw[1] <= {pw[1][7:0], data_byte};
        end
        if (pos >= 17'd16 && is_v6 && pos <= pvh_pkg::IPV6_END) begin
          if (pos < 17'd48) begin
            aw[pos[4:3] - 2'd2] <= {aw[pos[4:3] - 2'd2][55:0], data_byte};
          end else if (pos < 17'd50) pw[0] <= {pw[0][7:0], data_byte};
          else pw[1] <= {pw[1][7:0], data_byte};
        end
        // TLV walk.
        if (in_tlv) begin
          unique case (tlv_phase)
            pvh_pkg::PH_TYPE: begin
              tlv_type <= data_byte;
              tlv_length <= '0;
              tlv_phase <= pvh_pkg::PH_LEN_HI;
            end
            pvh_pkg::PH_LEN_HI: begin
              tlv_length <= {data_byte, 8'd0};
              tlv_phase <= pvh_pkg::PH_LEN_LO;
            end
            pvh_pkg::PH_LEN_LO: begin
              tlv_length <= len_full;
              tlv_offset <= '0;
              if (tlv_type == pvh_pkg::TLV_EPID) begin
                if (len_full == 16'd0) begin
                  status_reg <= pvh_pkg::ST_EMPTY_EPID;
                  tlv_phase <= pvh_pkg::PH_STOP;
                end else tlv_phase <= pvh_pkg::PH_VALUE;
              end else if (tlv_type == pvh_pkg::TLV_ID8) begin
                if (len_full != 16'd8) begin
                  status_reg <= pvh_pkg::ST_BAD_ID8_LEN;
                  tlv_phase <= pvh_pkg::PH_STOP;
                end else tlv_phase <= pvh_pkg::PH_VALUE;
              end else if (tlv_type == pvh_pkg::TLV_ID5) begin
                if (len_full != 16'd5) begin
                  status_reg <= pvh_pkg::ST_BAD_ID5_LEN;
                  tlv_phase <= pvh_pkg::PH_STOP;
                end else tlv_phase <= pvh_pkg::PH_VALUE;
              end else begin
                tlv_phase <= (len_full == 16'd0) ? pvh_pkg::PH_TYPE : pvh_pkg::PH_SKIP;
              end
            end
            pvh_pkg::PH_VALUE: begin
              if (tlv_type == pvh_pkg::TLV_EPID) begin
                if (store_we) id_count <= id_count + CW'(1);
              end else if (tlv_type == pvh_pkg::TLV_ID8) begin
                id_accumulator <= {id_accumulator[55:0], data_byte};
              end else if (tlv_offset == 16'd0) begin
                if (data_byte != pvh_pkg::ID5_VERSION) status_reg <= pvh_pkg::ST_BAD_ID5_VER;
              end else if (tlv_offset <= 16'd4) begin
                id_accumulator[{tlv_offset[1:0] - 2'd1, 3'b000} +: 8] <= data_byte;
              end
              if (tlv_type == pvh_pkg::TLV_ID5 && tlv_offset == 16'd0
                  && data_byte != pvh_pkg::ID5_VERSION) begin
                tlv_phase <= pvh_pkg::PH_STOP;
              end else if (off_inc >= tlv_length) begin
                tlv_phase <= pvh_pkg::PH_STOP;
              end else tlv_offset <= off_inc;
            end
            pvh_pkg::PH_SKIP: begin
              if (off_inc >= tlv_length) tlv_phase <= pvh_pkg::PH_TYPE;
              else tlv_offset <= off_inc;
            end
            default: ;
          endcase
        end
      end
    end
  end

  // Summary fields from the finished frame.
  logic vend, src_on;
  assign sum_kind = (ver_cmd_byte == pvh_pkg::CMD_LOCAL) ? pvh_pkg::KIND_LOCAL :
                    (family_byte == pvh_pkg::FAM_IPV4) ? pvh_pkg::KIND_IPV4 :
                    (family_byte == pvh_pkg::FAM_IPV6) ? pvh_pkg::KIND_IPV6 :
                    pvh_pkg::KIND_LOCAL;
  assign sum_status = status_reg;
  assign vend = tlv_type == pvh_pkg::TLV_EPID || tlv_type == pvh_pkg::TLV_ID8 ||
                tlv_type == pvh_pkg::TLV_ID5;
  assign src_on = vend && tlv_phase != pvh_pkg::PH_TYPE && tlv_phase != pvh_pkg::PH_SKIP;
  assign sum_src = !src_on ? pvh_pkg::SRC_NONE :
                   (tlv_type == pvh_pkg::TLV_EPID) ? pvh_pkg::SRC_EPID :
                   (tlv_type == pvh_pkg::TLV_ID8) ? pvh_pkg::SRC_ID8 : pvh_pkg::SRC_ID5;
  assign sum_vpc_id = (sum_src == pvh_pkg::SRC_ID8 || sum_src == pvh_pkg::SRC_ID5) ?
                      id_accumulator : 64'd0;
  assign addr0 = aw[0];
  assign addr1 = aw[1];
  assign addr2 = aw[2];
  assign addr3 = aw[3];
  assign port0 = pw[0];
  assign port1 = pw[1];

  // Read pointer over the id store.
  logic [AW-1:0] rd_addr;
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
    end else if (cmd.rd_start) begin
      rd_ptr <= '0;
    end else if (cmd.rd_next) begin
      rd_ptr <= rd_ptr + AW'(1);
    end
  end
  assign rd_addr = rd_ptr;

  pvh_ram #(.WIDTH(8), .DEPTH(pvh_pkg::ID_STORE_BYTES)) u_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(id_count[AW-1:0]),
    .wdata(data_byte),
    .raddr(rd_addr),
    .rdata(rd_byte)
  );

endmodule

[sv/proxy_v2_header_parser_top.sv]
// PROXY v2 header parser: one header byte per beat on the input stream,
// one summary beat then one beat per stored endpoint-id byte at header end.
// Depends on pvh_pkg, pvh_ctrl, pvh_dp and pvh_ram.
//
// Header bytes are taken at one per cycle. On the byte that ends the header
// the parser stops taking input and emits a summary beat, then for each of
// the N stored endpoint-id bytes (N up to 32) one beat, made of a store read
// and then an output load. No new header byte is taken before the last beat
// is loaded. The id store is a registered-read RAM with one read port.
module proxy_v2_header_parser_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  input  logic         s_tuser,   // frame_start
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[2:0], conn_kind[4:3], src_addr_hi[68:5], src_addr_lo[132:69],
  // dst_addr_hi[196:133], dst_addr_lo[260:197], source port[276:261],
  // destination port[292:277], vpc_source[294:293], vpc_id[358:295],
  // id_byte[366:359], zero fill [367]
  output logic [367:0] m_tdata,
  output logic         m_tlast
);

  pvh_pkg::pvh_cmd_t  cmd;
  pvh_pkg::pvh_stat_t stat;
  logic load_sum, load_id, out_free;
  logic [2:0] sum_status;
  logic [1:0] sum_kind, sum_src;
  logic [63:0] a0, a1, a2, a3, sum_vpc_id;
  logic [15:0] p0, p1;
  logic [7:0] rd_byte;

  assign out_free = !m_tvalid || m_tready;

  pvh_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .frame_start(s_tuser),
    .in_ready(s_tready), .out_load_sum(load_sum), .out_load_id(load_id),
    .out_free(out_free), .cmd(cmd), .stat(stat)
  );

  pvh_dp u_dp (
    .clk(clk), .rst(rst), .data_byte(s_tdata), .cmd(cmd), .stat(stat),
    .sum_status(sum_status), .sum_kind(sum_kind), .addr0(a0), .addr1(a1),
    .addr2(a2), .addr3(a3), .port0(p0), .port1(p1), .sum_src(sum_src),
    .sum_vpc_id(sum_vpc_id), .rd_byte(rd_byte)
  );

  // Output register; the store read pointer marks the final id beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (load_sum) begin
        m_tvalid <= 1'b1;
        m_tdata <= {1'b0, 8'd0, sum_vpc_id, sum_src, p1, p0, a3, a2, a1, a0,
                    sum_kind, sum_status};
        m_tlast <= (stat.id_count == '0);
      end else if (load_id) begin
        m_tvalid <= 1'b1;
        m_tdata <= {1'b0, rd_byte, 64'd0, 2'd0, 16'd0, 16'd0, 256'd0,
                    pvh_pkg::KIND_IDBYTE, 3'd0};
        m_tlast <= stat.rd_last;
      end
    end
  end

endmodule

[sv/pvh_checker.sv]
// Port-level checker of the PROXY v2 header parser, bound to the top level.
// Depends on proxy_v2_header_parser_top_defines.svh and pvh_pkg.
`include "proxy_v2_header_parser_top_defines.svh"
module pvh_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [367:0] m_tdata,
  input logic         m_tlast
);

  // Id-byte beats carry only the kind, the byte and last.
  `PVH_ASSERT(a_idbeat_clean, m_tvalid && m_tdata[4:3] == pvh_pkg::KIND_IDBYTE, m_tdata[358:0] == 359'(24), "id beat has stray fields")
  // Input is not taken while a run is being emitted.
  `PVH_ASSERT(a_no_in_when_out, m_tvalid && !m_tlast, !s_tready, "input taken mid run")
  // A stalled beat holds.
  `PVH_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled beat changed")

endmodule

bind proxy_v2_header_parser_top pvh_checker u_pvh_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
